// File: rtl/masmu_pkg.sv
// shared types and constants of the matrix add, subtract and multiply unit
`default_nettype none

package masmu_pkg;

    localparam int DATA_W = 32;
    localparam int IDX_W  = 3;
    localparam int OP_W   = 3;
    localparam int DIM_W  = 4;
    localparam int CFG_IDX_W = 1;

    localparam logic [OP_W-1:0] OP_LOAD_A = 3'd0;
    localparam logic [OP_W-1:0] OP_LOAD_B = 3'd1;
    localparam logic [OP_W-1:0] OP_ADD    = 3'd2;
    localparam logic [OP_W-1:0] OP_SUB    = 3'd3;
    localparam logic [OP_W-1:0] OP_MUL    = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'd1;

    typedef struct packed {
        logic             wr_a;
        logic             wr_b;
        logic             rd_en;
        logic [IDX_W-1:0] rd_row_a;
        logic [IDX_W-1:0] rd_col_a;
        logic [IDX_W-1:0] rd_row_b;
        logic [IDX_W-1:0] rd_col_b;
        logic             first;
        logic             last;
        logic             op_mul;
        logic             op_sub;
        logic             err_load;
        logic [IDX_W-1:0] out_row;
        logic [IDX_W-1:0] out_col;
        logic             out_last;
    } t_cmd;

    typedef struct packed {
        logic out_load;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

// File: rtl/masmu_ctrl.sv
// sequencer: shape registers, load decode and result run walk
`default_nettype none

module masmu_ctrl #(
    parameter int MAX_DIM = 8
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [masmu_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [masmu_pkg::DIM_W-1:0]         i_cfg_data,
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic [masmu_pkg::OP_W-1:0]          i_operation,
    input  wire logic [masmu_pkg::IDX_W-1:0]         i_row_index,
    input  wire logic [masmu_pkg::IDX_W-1:0]         i_column_index,
    input  wire masmu_pkg::t_stat                    i_stat,
    output masmu_pkg::t_cmd                          o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ISSUE = 2'd1;
    localparam logic [1:0] S_WAIT  = 2'd2;
    localparam logic [1:0] S_ERR   = 2'd3;

    localparam logic [masmu_pkg::DIM_W-1:0] DIM_MAX = masmu_pkg::DIM_W'(MAX_DIM);
    localparam logic [masmu_pkg::DIM_W-1:0] DIM_ONE = masmu_pkg::DIM_W'(1);

    logic [1:0]                       r_state, n_state;
    logic [masmu_pkg::DIM_W-1:0]      r_row_cfg, r_col_cfg;
    logic [masmu_pkg::IDX_W-1:0]      r_row, n_row;
    logic [masmu_pkg::IDX_W-1:0]      r_col, n_col;
    logic [masmu_pkg::IDX_W-1:0]      r_k, n_k;
    logic                             r_op_mul, n_op_mul;
    logic                             r_op_sub, n_op_sub;

    logic [masmu_pkg::DIM_W-1:0]      rows, cols;
    logic                             accept;
    logic                             in_range;
    logic                             k_end;
    logic                             col_end;
    logic                             elem_last;

    // 0 acts as 1, above the maximum acts as the maximum
    always_comb begin
        rows = r_row_cfg;
        if (r_row_cfg == '0) begin
            rows = DIM_ONE;
        end else if (r_row_cfg > DIM_MAX) begin
            rows = DIM_MAX;
        end
        cols = r_col_cfg;
        if (r_col_cfg == '0) begin
            cols = DIM_ONE;
        end else if (r_col_cfg > DIM_MAX) begin
            cols = DIM_MAX;
        end
    end

    assign o_stall   = (r_state != S_IDLE);
    assign accept    = i_valid && (r_state == S_IDLE);
    assign in_range  = ({1'b0, i_row_index} < rows) && ({1'b0, i_column_index} < cols);
    assign k_end     = !r_op_mul || ({1'b0, r_k} == cols - DIM_ONE);
    assign col_end   = ({1'b0, r_col} == cols - DIM_ONE);
    assign elem_last = ({1'b0, r_row} == rows - DIM_ONE) && col_end;

    always_comb begin
        n_state  = r_state;
        n_row    = r_row;
        n_col    = r_col;
        n_k      = r_k;
        n_op_mul = r_op_mul;
        n_op_sub = r_op_sub;

        o_cmd          = '0;
        o_cmd.first    = (r_k == '0);
        o_cmd.last     = k_end;
        o_cmd.op_mul   = r_op_mul;
        o_cmd.op_sub   = r_op_sub;
        o_cmd.out_row  = r_row;
        o_cmd.out_col  = r_col;
        o_cmd.out_last = elem_last;
        o_cmd.rd_row_a = r_row;
        o_cmd.rd_col_a = r_op_mul ? r_k : r_col;
        o_cmd.rd_row_b = r_op_mul ? r_k : r_row;
        o_cmd.rd_col_b = r_col;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_row = '0;
                    n_col = '0;
                    n_k   = '0;
                    unique case (i_operation) inside
                        masmu_pkg::OP_LOAD_A: begin
                            o_cmd.wr_a = in_range;
                        end
                        masmu_pkg::OP_LOAD_B: begin
                            o_cmd.wr_b = in_range;
                        end
                        masmu_pkg::OP_ADD, masmu_pkg::OP_SUB: begin
                            n_op_mul = 1'b0;
                            n_op_sub = (i_operation == masmu_pkg::OP_SUB);
                            n_state  = S_ISSUE;
                        end
                        masmu_pkg::OP_MUL: begin
                            n_op_mul = 1'b1;
                            n_op_sub = 1'b0;
                            n_state  = (rows != cols) ? S_ERR : S_ISSUE;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_ISSUE: begin
                o_cmd.rd_en = i_stat.out_free;
                if (i_stat.out_free) begin
                    if (k_end) begin
                        n_k     = '0;
                        n_state = S_WAIT;
                    end else begin
                        n_k = r_k + 1'b1;
                    end
                end
            end
            S_WAIT: begin
                if (i_stat.out_load) begin
                    if (elem_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_ISSUE;
                        if (col_end) begin
                            n_col = '0;
                            n_row = r_row + 1'b1;
                        end else begin
                            n_col = r_col + 1'b1;
                        end
                    end
                end
            end
            S_ERR: begin
                o_cmd.err_load = i_stat.out_free;
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_row_cfg <= DIM_MAX;
            r_col_cfg <= DIM_MAX;
            r_row     <= '0;
            r_col     <= '0;
            r_k       <= '0;
            r_op_mul  <= 1'b0;
            r_op_sub  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_row    <= n_row;
            r_col    <= n_col;
            r_k      <= n_k;
            r_op_mul <= n_op_mul;
            r_op_sub <= n_op_sub;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    masmu_pkg::REG_ROW_COUNT:    r_row_cfg <= i_cfg_data;
                    masmu_pkg::REG_COLUMN_COUNT: r_col_cfg <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/masmu_dp.sv
// datapath: matrix memories, multiply, add or subtract stage, accumulator, output register
`default_nettype none

module masmu_dp #(
    parameter int MAX_DIM = 8
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire masmu_pkg::t_cmd                    i_cmd,
    output masmu_pkg::t_stat                        o_stat,
    input  wire logic [masmu_pkg::IDX_W-1:0]        i_row_index,
    input  wire logic [masmu_pkg::IDX_W-1:0]        i_column_index,
    input  wire logic [masmu_pkg::DATA_W-1:0]       i_element_value,
    output logic                                    o_valid,
    input  wire logic                               i_stall,
    output logic [masmu_pkg::DATA_W-1:0]            o_result_value,
    output logic [masmu_pkg::IDX_W-1:0]             o_result_row,
    output logic [masmu_pkg::IDX_W-1:0]             o_result_column,
    output logic                                    o_last_element,
    output logic                                    o_shape_error
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [masmu_pkg::DATA_W-1:0] mem_a [0:DEPTH-1];
    logic [masmu_pkg::DATA_W-1:0] mem_b [0:DEPTH-1];

    logic [masmu_pkg::DATA_W-1:0] r_a_q, r_b_q;
    logic                         r_s1_v, r_s1_first, r_s1_last;
    logic [masmu_pkg::DATA_W-1:0] r_s2_val;
    logic                         r_s2_v, r_s2_first, r_s2_last;
    logic [masmu_pkg::DATA_W-1:0] r_acc;
    logic [masmu_pkg::DATA_W-1:0] acc_next;
    logic                         r_out_v;
    logic                         out_load;

    logic [AW-1:0]     wr_addr, rda_addr, rdb_addr;

    assign wr_addr  = AW'(i_row_index) * AW'(MAX_DIM) + AW'(i_column_index);
    assign rda_addr = AW'(i_cmd.rd_row_a) * AW'(MAX_DIM) + AW'(i_cmd.rd_col_a);
    assign rdb_addr = AW'(i_cmd.rd_row_b) * AW'(MAX_DIM) + AW'(i_cmd.rd_col_b);

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_a) begin
            mem_a[wr_addr] <= i_element_value;
        end
        if (i_cmd.wr_b) begin
            mem_b[wr_addr] <= i_element_value;
        end
        if (i_cmd.rd_en) begin
            r_a_q <= mem_a[rda_addr];
            r_b_q <= mem_b[rdb_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_v) begin
            if (i_cmd.op_mul) begin
                r_s2_val <= r_a_q * r_b_q;
            end else if (i_cmd.op_sub) begin
                r_s2_val <= r_a_q - r_b_q;
            end else begin
                r_s2_val <= r_a_q + r_b_q;
            end
        end
    end

    assign acc_next = r_s2_first ? r_s2_val : r_acc + r_s2_val;

    assign out_load        = (r_s2_v && r_s2_last) || i_cmd.err_load;
    assign o_stat.out_load = r_s2_v && r_s2_last;
    assign o_stat.out_free = !r_out_v || !i_stall;

    always_ff @(posedge i_clk) begin
        if (r_s2_v) begin
            r_acc <= acc_next;
        end
        if (r_s2_v && r_s2_last) begin
            o_result_value  <= acc_next;
            o_result_row    <= i_cmd.out_row;
            o_result_column <= i_cmd.out_col;
            o_last_element  <= i_cmd.out_last;
            o_shape_error   <= 1'b0;
        end else if (i_cmd.err_load) begin
            o_result_value  <= '0;
            o_result_row    <= '0;
            o_result_column <= '0;
            o_last_element  <= 1'b1;
            o_shape_error   <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v     <= 1'b0;
            r_s1_first <= 1'b0;
            r_s1_last  <= 1'b0;
            r_s2_v     <= 1'b0;
            r_s2_first <= 1'b0;
            r_s2_last  <= 1'b0;
            r_out_v    <= 1'b0;
        end else begin
            r_s1_v     <= i_cmd.rd_en;
            r_s1_first <= i_cmd.first;
            r_s1_last  <= i_cmd.last;
            r_s2_v     <= r_s1_v;
            r_s2_first <= r_s1_first;
            r_s2_last  <= r_s1_last;
            if (out_load) begin
                r_out_v <= 1'b1;
            end else if (!i_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_v;

endmodule

`default_nettype wire

// File: rtl/matrix_add_sub_mul_unit_top.sv
// top level of the matrix add, subtract and multiply unit
`default_nettype none

// Holds two matrices A and B of up to MAX_DIM x MAX_DIM 32-bit elements, one
// single-port-read memory each. A load item writes one element, and it
// is dropped if it falls outside the shape set by row_count and column_count.
// A compute item streams its result in row-major order with the final element
// flagged; the input stalls until the last element is in the output register.
// Add and subtract pass each element through memory read, add stage and output
// load; multiply reads each memory column_count times per element, one read per
// cycle while the output is free, feeding the single multiplier and accumulator.
// A multiply on a non-square shape returns one result with shape_error set.
// Elements never written read back as undefined values.

module matrix_add_sub_mul_unit_top #(
    parameter int MAX_DIM = 8
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [masmu_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [masmu_pkg::DIM_W-1:0]        i_cfg_data,
    input  wire logic                               i_valid,
    output logic                                    o_stall,
    input  wire logic [masmu_pkg::OP_W-1:0]         i_operation,
    input  wire logic [masmu_pkg::IDX_W-1:0]        i_row_index,
    input  wire logic [masmu_pkg::IDX_W-1:0]        i_column_index,
    input  wire logic signed [masmu_pkg::DATA_W-1:0] i_element_value,
    output logic                                    o_valid,
    input  wire logic                               i_stall,
    output logic signed [masmu_pkg::DATA_W-1:0]     o_result_value,
    output logic [masmu_pkg::IDX_W-1:0]             o_result_row,
    output logic [masmu_pkg::IDX_W-1:0]             o_result_column,
    output logic                                    o_last_element,
    output logic                                    o_shape_error
);

    masmu_pkg::t_cmd  cmd;
    masmu_pkg::t_stat stat;
    logic [masmu_pkg::DATA_W-1:0] result_value;

    masmu_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_operation    (i_operation),
        .i_row_index    (i_row_index),
        .i_column_index (i_column_index),
        .i_stat         (stat),
        .o_cmd          (cmd)
    );

    masmu_dp #(
        .MAX_DIM (MAX_DIM)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_row_index     (i_row_index),
        .i_column_index  (i_column_index),
        .i_element_value (i_element_value),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_result_value  (result_value),
        .o_result_row    (o_result_row),
        .o_result_column (o_result_column),
        .o_last_element  (o_last_element),
        .o_shape_error   (o_shape_error)
    );

    assign o_result_value = result_value;

endmodule

`default_nettype wire
